// ===== src/nnue_pkg.sv =====
// ----------------------------------------------------------------------------
// NNUE evaluator package
// Shared constants, types and a helper function of the accumulator evaluator.
// ----------------------------------------------------------------------------
package nnue_pkg;

    localparam int ACC_WIDTH     = 128;
    localparam int BUCKET_COUNT  = 30;
    localparam int FEATURE_COUNT = 768;

    localparam int FW_DEPTH = FEATURE_COUNT * ACC_WIDTH;
    localparam int OW_DEPTH = BUCKET_COUNT * 2 * ACC_WIDTH;

    localparam int IDX_W  = $clog2(ACC_WIDTH);
    localparam int FEAT_W = $clog2(FEATURE_COUNT);
    localparam int FW_AW  = $clog2(FW_DEPTH);
    localparam int OW_AW  = $clog2(OW_DEPTH);
    localparam int BK_W   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int ACC_AW = IDX_W + 1;

    localparam int ACT_MAX       = 63;
    localparam int CP_SCALE      = 100;
    localparam int RANK_FLIP     = 6'b111000;
    localparam int COLOUR_STRIDE = 6 * 64;
    localparam int DIVISOR       = ACT_MAX * ACT_MAX;

    localparam int SUM_W = 48;

    // The score is the magnitude of the sum times a scaled reciprocal of
    // DIVISOR that already includes CP_SCALE, exact for sums below 2^30.
    localparam int MAG_W       = 32;
    localparam int RECIP_W     = 37;
    localparam int RECIP_SHIFT = 42;
    localparam int RECIP_SPLIT = 19;
    localparam int LO_W        = MAG_W + RECIP_SPLIT;
    localparam int HI_W        = MAG_W + RECIP_W - RECIP_SPLIT;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(CP_SCALE) << RECIP_SHIFT) + longint'(DIVISOR) - 64'sd1)
                 / longint'(DIVISOR));

    typedef enum logic [2:0] {
        MODE_LOAD     = 3'd0,
        MODE_PRESET   = 3'd1,
        MODE_ADD      = 3'd2,
        MODE_SUBTRACT = 3'd3,
        MODE_EVALUATE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        TBL_FEATURE  = 2'd0,
        TBL_BIAS     = 2'd1,
        TBL_OUT_W    = 2'd2,
        TBL_OUT_BIAS = 2'd3
    } table_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EVAL,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  table_select;
        logic [16:0] load_address;
        logic [15:0] load_value;
        logic [2:0]  piece_kind;
        logic        piece_is_white;
        logic [5:0]  board_square;
        logic        view_white;
        logic        acc_pick;
        logic [4:0]  bucket;
        logic        mover_pick;
    } item_t;

    function automatic logic [5:0] clamp_act(input logic [15:0] v);
        logic [5:0] r;
        begin
            if (v[15] || v == 16'd0)
                r = 6'd0;
            else if (v >= 16'(ACT_MAX))
                r = 6'(ACT_MAX);
            else
                r = v[5:0];
            return r;
        end
    endfunction

endpackage

// ===== src/nnue_if.sv =====
// ----------------------------------------------------------------------------
// NNUE stream interfaces
// Valid/ready channels for input items and score results.
// ----------------------------------------------------------------------------
interface nnue_in_if
    import nnue_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nnue_out_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] score;
    modport source (output valid, output score, input ready);
    modport sink (input valid, input score, output ready);
endinterface

// ===== src/nnue_accumulator_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// NNUE accumulator evaluator
// Weight tables and two accumulators in synchronous memories, updated by
// read-modify-write walks and reduced by a multiply-accumulate evaluation.
// ----------------------------------------------------------------------------
// A load is written on acceptance; preset, add and subtract walk the ACC_WIDTH
// entries of one accumulator. An evaluation accumulates the 2 * ACC_WIDTH
// entries of both accumulators one at a time, as set by the single read port
// of the weight memory, then scales the sum by the reciprocal in the divider.
// Throughput is one item at a time. Reset clears the accumulators through
// valid bits at once; the tables are undefined until loaded.
module nnue_accumulator_evaluator_top
    import nnue_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    nnue_in_if.sink    in_ch,
    nnue_out_if.source out_ch
);
    state_t state_reg, state_next;
    item_t  item_reg;

    logic [ACC_AW:0]  cnt_reg, cnt_next;
    logic [2*ACC_WIDTH-1:0] vld_reg;

    // Pipeline of the walk: stage 1 holds the address issued last cycle.
    logic              p1_reg;
    logic [ACC_AW-1:0] p1_addr_reg;
    logic              p2_reg;
    logic [5:0]        act_reg;
    logic signed [15:0] ow_reg;
    logic signed [21:0] prod_reg;
    logic              p3_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [24:0] score_reg;
    logic              out_valid_reg;

    logic [FEAT_W-1:0] feat;
    logic [1:0]        colour;
    logic [5:0]        sq;
    logic [BK_W-1:0]   bk;
    logic              accept;
    logic              walk_issue;
    logic              div_start, div_done;
    logic signed [24:0] div_q;

    logic              fw_we, ab_we, ow_we, ob_we;
    logic [FW_AW-1:0]  fw_raddr;
    logic [IDX_W-1:0]  ab_raddr;
    logic [OW_AW-1:0]  ow_raddr;
    logic [15:0]       fw_q, ab_q, ow_q, ob_q;

    logic              acc_we;
    logic [ACC_AW-1:0] acc_waddr, acc_raddr;
    logic [15:0]       acc_wdata, acc_q, acc_val;
    logic [15:0]       acc_mem [2*ACC_WIDTH];
    logic [15:0]       ob_mem [BUCKET_COUNT];

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;

    assign bk = (in_ch.data.bucket >= 5'(BUCKET_COUNT)) ? BK_W'(BUCKET_COUNT - 1)
                                                          : BK_W'(in_ch.data.bucket);
    logic [BK_W-1:0] bk_reg;

    always_comb
    begin
        colour = in_ch.data.view_white ? {1'b0, in_ch.data.piece_is_white}
                                       : {1'b0, !in_ch.data.piece_is_white};
        sq = in_ch.data.view_white ? in_ch.data.board_square
                                   : (in_ch.data.board_square ^ 6'(RANK_FLIP));
        feat = FEAT_W'(colour) * FEAT_W'(COLOUR_STRIDE)
             + FEAT_W'(in_ch.data.piece_kind) * FEAT_W'(64) + FEAT_W'(sq);
    end
    logic [FEAT_W-1:0] feat_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_ch.data.mode == MODE_PRESET)
                        state_next = ST_UPDATE;
                    else if ((in_ch.data.mode == MODE_ADD ||
                              in_ch.data.mode == MODE_SUBTRACT) &&
                             in_ch.data.piece_kind <= 3'd5)
                        state_next = ST_UPDATE;
                    else if (in_ch.data.mode == MODE_EVALUATE)
                        state_next = ST_EVAL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_UPDATE:
                if (cnt_reg == (ACC_AW+1)'(ACC_WIDTH + 2))
                    state_next = ST_IDLE;
            ST_EVAL:
                if (cnt_reg == (ACC_AW+1)'(2 * ACC_WIDTH + 4))
                    state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (div_done)
                    state_next = ST_OUTPUT;
            ST_OUTPUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next   = '0;
        walk_issue = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_UPDATE:
            begin
                cnt_next   = cnt_reg + 1'b1;
                walk_issue = cnt_reg < (ACC_AW+1)'(ACC_WIDTH);
            end
            ST_EVAL:
            begin
                cnt_next   = cnt_reg + 1'b1;
                walk_issue = cnt_reg < (ACC_AW+1)'(2 * ACC_WIDTH);
                div_start  = cnt_reg == (ACC_AW+1)'(2 * ACC_WIDTH + 4);
            end
            default:
                cnt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            p3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            p1_reg    <= walk_issue;
            p2_reg    <= p1_reg && (state_reg == ST_EVAL);
            p3_reg    <= p2_reg;
            if (acc_we)
                vld_reg[acc_waddr] <= 1'b1;
            if (state_reg == ST_DIVIDE && div_done)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_ch.data;
            feat_reg <= feat;
            bk_reg   <= bk;
        end
        p1_addr_reg <= acc_raddr;
        act_reg     <= clamp_act(acc_val);
        ow_reg      <= ow_q;
        prod_reg    <= $signed({1'b0, act_reg}) * ow_reg;
        if (state_reg == ST_IDLE)
            sum_reg <= '0;
        else if (state_reg == ST_EVAL && cnt_reg == (ACC_AW+1)'(1))
            sum_reg <= SUM_W'($signed(ob_q));
        else if (p3_reg)
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        if (state_reg == ST_DIVIDE && div_done)
            score_reg <= div_q;
    end

    // Accumulator memory; each update entry is read and written once, so no
    // overlap between read and write of the same entry occurs.
    always_comb
    begin
        if (state_reg == ST_EVAL)
            acc_raddr = cnt_reg[IDX_W] ? ACC_AW'({!item_reg.mover_pick, cnt_reg[IDX_W-1:0]})
                                       : ACC_AW'({item_reg.mover_pick, cnt_reg[IDX_W-1:0]});
        else
            acc_raddr = ACC_AW'({item_reg.acc_pick, cnt_reg[IDX_W-1:0]});
        acc_val   = vld_reg[p1_addr_reg] ? acc_q : 16'd0;
        acc_we    = p1_reg && (state_reg == ST_UPDATE);
        acc_waddr = p1_addr_reg;
        priority if (item_reg.mode == MODE_PRESET)
            acc_wdata = ab_q;
        else if (item_reg.mode == MODE_SUBTRACT)
            acc_wdata = acc_val - fw_q;
        else
            acc_wdata = acc_val + fw_q;
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_waddr] <= acc_wdata;
        acc_q <= acc_mem[acc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ob_we)
            ob_mem[BK_W'(in_ch.data.load_address)] <= in_ch.data.load_value;
        ob_q <= ob_mem[bk_reg];
    end

    assign fw_we = accept && in_ch.data.mode == MODE_LOAD &&
                   in_ch.data.table_select == TBL_FEATURE &&
                   in_ch.data.load_address < 17'(FW_DEPTH);
    assign ab_we = accept && in_ch.data.mode == MODE_LOAD &&
                   in_ch.data.table_select == TBL_BIAS &&
                   in_ch.data.load_address < 17'(ACC_WIDTH);
    assign ow_we = accept && in_ch.data.mode == MODE_LOAD &&
                   in_ch.data.table_select == TBL_OUT_W &&
                   in_ch.data.load_address < 17'(OW_DEPTH);
    assign ob_we = accept && in_ch.data.mode == MODE_LOAD &&
                   in_ch.data.table_select == TBL_OUT_BIAS &&
                   in_ch.data.load_address < 17'(BUCKET_COUNT);

    assign fw_raddr = FW_AW'(feat_reg) * FW_AW'(ACC_WIDTH) + FW_AW'(cnt_reg[IDX_W-1:0]);
    assign ab_raddr = cnt_reg[IDX_W-1:0];
    assign ow_raddr = OW_AW'(bk_reg) * OW_AW'(2 * ACC_WIDTH) + OW_AW'(cnt_reg[IDX_W:0]);

    nnue_ram #(.DEPTH(FW_DEPTH), .AW(FW_AW)) u_fw (
        .clk   (clk),
        .we    (fw_we),
        .waddr (in_ch.data.load_address[FW_AW-1:0]),
        .wdata (in_ch.data.load_value),
        .raddr (fw_raddr),
        .rdata (fw_q)
    );

    nnue_ram #(.DEPTH(ACC_WIDTH), .AW(IDX_W)) u_ab (
        .clk   (clk),
        .we    (ab_we),
        .waddr (in_ch.data.load_address[IDX_W-1:0]),
        .wdata (in_ch.data.load_value),
        .raddr (ab_raddr),
        .rdata (ab_q)
    );

    nnue_ram #(.DEPTH(OW_DEPTH), .AW(OW_AW)) u_ow (
        .clk   (clk),
        .we    (ow_we),
        .waddr (in_ch.data.load_address[OW_AW-1:0]),
        .wdata (in_ch.data.load_value),
        .raddr (ow_raddr),
        .rdata (ow_q)
    );

    nnue_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_ch.valid = out_valid_reg;
    assign out_ch.score = score_reg;
endmodule

// ===== src/nnue_ram.sv =====
// ----------------------------------------------------------------------------
// NNUE generic RAM
// Single-port write, single-port read memory with a registered read.
// ----------------------------------------------------------------------------
module nnue_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);
    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== src/nnue_div.sv =====
// ----------------------------------------------------------------------------
// NNUE score divider
// Scales a signed sum and divides it by the constant divisor through a
// pipelined reciprocal multiplication, truncating toward zero.
// ----------------------------------------------------------------------------
module nnue_div
    import nnue_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    output logic                    done,
    output logic signed [24:0]      quotient
);
    logic [SUM_W-1:0]   abs_val;
    logic [MAG_W-1:0]   mag_reg;
    logic [LO_W-1:0]    lo_reg;
    logic [HI_W-1:0]    hi_reg;
    logic [PROD_W-1:0]  prod;
    logic [24:0]        quo_mag;
    logic signed [24:0] quo_reg;
    logic               neg1_reg, neg2_reg;
    logic               s1_reg, s2_reg, done_reg;

    assign abs_val = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    assign prod    = {hi_reg, {RECIP_SPLIT{1'b0}}} + PROD_W'(lo_reg);
    assign quo_mag = prod[RECIP_SHIFT+24:RECIP_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= start;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= abs_val[MAG_W-1:0];
        neg1_reg <= dividend[SUM_W-1];
        lo_reg   <= LO_W'(mag_reg) * LO_W'(RECIP[RECIP_SPLIT-1:0]);
        hi_reg   <= HI_W'(mag_reg) * HI_W'(RECIP[RECIP_W-1:RECIP_SPLIT]);
        neg2_reg <= neg1_reg;
        quo_reg  <= neg2_reg ? 25'(-quo_mag) : quo_mag;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule
